/* rtl/lzwcd_pkg.sv */
package lzwcd_pkg;

  // Fixed field widths.
  localparam int CODE_W = 16;
  localparam int BYTE_W = 8;

  // Dictionary and string limits.
  localparam int DICT_ENTRIES = 65536;
  localparam int MAX_STRING   = 64;
  localparam int FIRST_ENTRY  = 256;

  // Derived widths.
  localparam int DICT_AW = $clog2(DICT_ENTRIES);
  localparam int NF_W    = DICT_AW + 1;
  localparam int CMP_W   = CODE_W + 1;
  localparam int STK_AW  = $clog2(MAX_STRING);
  localparam int CNT_W   = $clog2(MAX_STRING + 2);

  // Error codes carried with each result word.
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE = 2'd0;
  localparam err_t ERR_CODE = 2'd1;
  localparam err_t ERR_LONG = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] code_word;
    logic              new_stream;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    err_t              error_code;
  } out_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] suffix;
  } dict_entry_t;

  localparam int DICT_W = $bits(dict_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic first_take;
    logic err_code;
    logic walk_start;
    logic walk_step;
    logic dict_update;
    logic emit_load;
    logic pop_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_prev;
    logic code_small;
    logic code_bad;
    logic walk_done;
    logic too_long;
    logic pop_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/lzwcd_ram.sv */
module lzwcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lzwcd_ctrl.sv */
module lzwcd_ctrl
  import lzwcd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_WALK   = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_POP    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.have_prev) begin
          if (sts.code_small) begin
            cmd.first_take = 1'b1;
          end else begin
            cmd.err_code = 1'b1;
          end
          state_nxt = ST_EMIT;
        end else if (sts.code_bad) begin
          cmd.err_code = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.dict_update = 1'b1;
        state_nxt = sts.too_long ? ST_EMIT : ST_POP;
      end
      ST_POP: begin
        if (sts.out_free) begin
          cmd.pop_load = 1'b1;
          if (sts.pop_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/lzwcd_dp.sv */
module lzwcd_dp
  import lzwcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  logic      out_ready,
  output logic      out_valid,
  output out_word_t out_word,
  input  cmd_t      cmd,
  output sts_t      sts
);

  // Control state.
  logic              have_prev_r, have_prev_nxt;
  logic [NF_W-1:0]   nf_r, nf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CODE_W-1:0] prev_code_r, prev_code_nxt;
  logic [BYTE_W-1:0] prev_first_r, prev_first_nxt;
  logic [CODE_W-1:0] walk_r, walk_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  out_word_t         single_r, single_nxt;
  out_word_t         out_word_r, out_word_nxt;

  // Memory ports.
  logic              dict_we;
  logic [DICT_AW-1:0] dict_waddr;
  dict_entry_t       dict_wdata;
  dict_entry_t       dict_rdata;
  logic              stk_we;
  logic [STK_AW-1:0] stk_waddr;
  logic [BYTE_W-1:0] stk_wdata;
  logic [STK_AW-1:0] stk_raddr;
  logic [BYTE_W-1:0] stk_rdata;

  logic              kwkwk;
  logic              push_en;
  logic [BYTE_W-1:0] push_byte;
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W-1:0]  cnt_dec;

  assign kwkwk = (CMP_W'(code_r) == CMP_W'(nf_r));

  assign sts.have_prev  = have_prev_r;
  assign sts.code_small = (code_r[CODE_W-1:BYTE_W] == '0);
  assign sts.code_bad   = (CMP_W'(code_r) > CMP_W'(nf_r)) ||
                          (kwkwk && (nf_r == NF_W'(DICT_ENTRIES)));
  assign sts.walk_done  = (walk_r[CODE_W-1:BYTE_W] == '0);
  assign sts.too_long   = (cnt_r > CNT_W'(MAX_STRING));
  assign sts.pop_last   = (cnt_r == CNT_W'(1));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    have_prev_nxt  = have_prev_r;
    nf_nxt         = nf_r;
    code_nxt       = code_r;
    prev_code_nxt  = prev_code_r;
    prev_first_nxt = prev_first_r;
    walk_nxt       = walk_r;
    first_nxt      = first_r;
    single_nxt     = single_r;
    cnt_nxt        = cnt_r;
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    push_en        = 1'b0;
    push_byte      = dict_rdata.suffix;
    cnt_base       = cmd.walk_start ? '0 : cnt_r;
    cnt_dec        = cnt_r - CNT_W'(1);
    dict_we        = 1'b0;
    dict_waddr     = nf_r[DICT_AW-1:0];
    dict_wdata     = '{prefix: prev_code_r, suffix: first_r};

    if (cmd.accept) begin
      code_nxt = in_word.code_word;
      if (in_word.new_stream) begin
        nf_nxt        = NF_W'(FIRST_ENTRY);
        have_prev_nxt = 1'b0;
      end
    end

    if (cmd.first_take) begin
      prev_code_nxt  = code_r;
      prev_first_nxt = code_r[BYTE_W-1:0];
      have_prev_nxt  = 1'b1;
      single_nxt     = '{data_byte: code_r[BYTE_W-1:0], last_byte: 1'b1,
                         error_code: ERR_NONE};
    end

    if (cmd.err_code) begin
      single_nxt = '{data_byte: '0, last_byte: 1'b1, error_code: ERR_CODE};
    end

    if (cmd.walk_start) begin
      cnt_nxt  = '0;
      walk_nxt = kwkwk ? prev_code_r : code_r;
      if (kwkwk) begin
        push_en   = 1'b1;
        push_byte = prev_first_r;
      end
    end

    if (cmd.walk_step) begin
      push_en = 1'b1;
      if (sts.walk_done) begin
        push_byte = walk_r[BYTE_W-1:0];
        first_nxt = walk_r[BYTE_W-1:0];
      end else begin
        push_byte = dict_rdata.suffix;
        walk_nxt  = dict_rdata.prefix;
      end
    end

    // The count saturates one past the stack depth to flag an overlong string.
    if (push_en && (cnt_base != CNT_W'(MAX_STRING + 1))) begin
      cnt_nxt = cnt_base + CNT_W'(1);
    end

    if (cmd.dict_update) begin
      if (nf_r < NF_W'(DICT_ENTRIES)) begin
        dict_we = 1'b1;
        nf_nxt  = nf_r + NF_W'(1);
      end
      prev_code_nxt  = code_r;
      prev_first_nxt = first_r;
      if (sts.too_long) begin
        single_nxt = '{data_byte: '0, last_byte: 1'b1, error_code: ERR_LONG};
      end
    end

    if (cmd.emit_load) begin
      out_word_nxt  = single_r;
      out_valid_nxt = 1'b1;
    end

    if (cmd.pop_load) begin
      out_word_nxt  = '{data_byte: stk_rdata, last_byte: sts.pop_last,
                        error_code: ERR_NONE};
      out_valid_nxt = 1'b1;
      cnt_nxt       = cnt_dec;
    end
  end

  assign stk_we    = push_en && (cnt_base < CNT_W'(MAX_STRING));
  assign stk_waddr = cnt_base[STK_AW-1:0];
  assign stk_wdata = push_byte;

  // Read ahead at the next top of stack so the byte of each pop is ready when it is taken.
  always_comb begin
    logic [CNT_W-1:0] top;
    top       = cnt_nxt - CNT_W'(1);
    stk_raddr = top[STK_AW-1:0];
  end

  lzwcd_ram #(
    .WIDTH(DICT_W),
    .DEPTH(DICT_ENTRIES)
  ) u_dict_ram (
    .clk  (clk),
    .we   (dict_we),
    .waddr(dict_waddr),
    .wdata(dict_wdata),
    .raddr(walk_nxt[DICT_AW-1:0]),
    .rdata(dict_rdata)
  );

  lzwcd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_STRING)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      nf_r         <= NF_W'(FIRST_ENTRY);
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      prev_code_r  <= '0;
      prev_first_r <= '0;
    end else begin
      have_prev_r  <= have_prev_nxt;
      nf_r         <= nf_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_code_r  <= prev_code_nxt;
      prev_first_r <= prev_first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    walk_r     <= walk_nxt;
    first_r    <= first_nxt;
    single_r   <= single_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The next free entry stays between the first entry and one past the last dictionary entry.
  a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nf_r >= NF_W'(FIRST_ENTRY)) && (nf_r <= NF_W'(DICT_ENTRIES)))
    else $error("next free entry out of range");

  // Every prefix points to an older entry, so the chain walk strictly descends.
  a_walk_desc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_step && !sts.walk_done) |=> (walk_r < $past(walk_r)))
    else $error("dictionary chain did not descend");

  // An error result is always the only and therefore the last word of its code.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.error_code != ERR_NONE)) |-> out_word_r.last_byte)
    else $error("error word without last mark");

  // A chain is only walked once a previous string exists.
  a_walk_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_start || cmd.walk_step) |-> have_prev_r)
    else $error("chain walk without previous code");

endmodule

/* rtl/lzw_code_decoder_core.sv */
// Channel  Ports                          Word type    Accepted when
// input    in_valid, in_ready, in_word    in_word_t    in_valid && in_ready
// result   out_valid, out_ready, out_word out_word_t   out_valid && out_ready
//
// Steps per code: accept, check, one walk step per chain entry plus one for the final
// byte, one to add the new entry and one pop per byte. KwKwK saves one walk step. A
// first or rejected code goes from the check to one emitted word; an over-long string
// walks, adds its entry and emits one error word. Reset clears the control state, the
// previous code and its first byte only. A stalled result side holds the pop, and the
// next code is taken once the last word sits in the output register.
module lzw_code_decoder_core
  import lzwcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // The controller sequences check, walk, update, pop and emit; the datapath holds
  // the dictionary, the reverse stack and the output register.
  cmd_t cmd;
  sts_t sts;

  lzwcd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lzwcd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_word (out_word),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lzwcd_pkg::*;

  // Run limits. Even with every code at its longest string under the heaviest
  // stalls the run needs well under half a millisecond, so the guard time is
  // set far above that.
  localparam int  HOLD_CYCLES = 400;
  localparam int  TAIL_CYCLES = 200;
  localparam int  SHOWN_FAILS = 40;
  localparam time RUN_LIMIT   = 4_000_000;

  // String tracker: keeps its own copy of the decoder's dictionary and
  // predicts, for every accepted code, the words the block must return.
  class lzw_string_tracker;
    logic [CODE_W-1:0] prefix_of [DICT_ENTRIES];
    logic [BYTE_W-1:0] suffix_of [DICT_ENTRIES];
    int unsigned       next_entry;
    logic [CODE_W-1:0] last_code;
    logic [BYTE_W-1:0] last_head;
    bit                have_string;
    out_word_t         pending_bytes[$];
    int                fails;
    int                n_codes;
    int                n_words;
    int                n_bad_code;
    int                n_too_long;
    int                n_full;
    int                longest;

    function new();
      next_entry  = FIRST_ENTRY;
      last_code   = '0;
      last_head   = '0;
      have_string = 1'b0;
      fails       = 0;
      n_codes     = 0;
      n_words     = 0;
      n_bad_code  = 0;
      n_too_long  = 0;
      n_full      = 0;
      longest     = 0;
    endfunction

    task report_mismatch(string what);
      fails++;
      if (fails <= SHOWN_FAILS) $display("%0t ns  mismatch: %s", $time, what);
    endtask

    function void push_word(logic [BYTE_W-1:0] data, logic last, err_t err);
      out_word_t w;
      w.data_byte  = data;
      w.last_byte  = last;
      w.error_code = err;
      pending_bytes.push_back(w);
      if (err == ERR_CODE) n_bad_code++;
      if (err == ERR_LONG) n_too_long++;
    endfunction

    // Works out the words caused by one accepted code and updates the
    // dictionary the same way the block must.
    function void expand_code(in_word_t w);
      int unsigned       code;
      int unsigned       walk;
      int                k;
      logic [BYTE_W-1:0] rev[$];
      logic [BYTE_W-1:0] head;

      code = w.code_word;
      n_codes++;
      // A restart applies even if the code that carries it is rejected.
      if (w.new_stream) begin
        next_entry  = FIRST_ENTRY;
        have_string = 1'b0;
      end

      // The first code of a stream must be a plain byte.
      if (!have_string) begin
        if (code >= FIRST_ENTRY) begin
          push_word('0, 1'b1, ERR_CODE);
          return;
        end
        push_word(w.code_word[BYTE_W-1:0], 1'b1, ERR_NONE);
        last_code   = w.code_word;
        last_head   = w.code_word[BYTE_W-1:0];
        have_string = 1'b1;
        if (longest < 1) longest = 1;
        return;
      end

      if (code > next_entry || (code == next_entry && next_entry >= DICT_ENTRIES)) begin
        push_word('0, 1'b1, ERR_CODE);
        return;
      end

      // The bytes are gathered last byte first while walking the prefix chain.
      if (code == next_entry) begin
        rev.push_back(last_head);
        walk = last_code;
      end else begin
        walk = code;
      end
      while (walk >= FIRST_ENTRY) begin
        rev.push_back(suffix_of[walk]);
        walk = prefix_of[walk];
      end
      head = walk[BYTE_W-1:0];
      rev.push_back(head);

      // The new entry is added even for an over-long string; a full
      // dictionary stays frozen.
      if (next_entry < DICT_ENTRIES) begin
        prefix_of[next_entry] = last_code;
        suffix_of[next_entry] = head;
        next_entry++;
        if (next_entry == DICT_ENTRIES) n_full++;
      end
      last_code = w.code_word;
      last_head = head;

      if (rev.size() > MAX_STRING) begin
        push_word('0, 1'b1, ERR_LONG);
        return;
      end
      if (rev.size() > longest) longest = rev.size();
      for (k = rev.size() - 1; k >= 0; k--) push_word(rev[k], k == 0, ERR_NONE);
    endfunction

    // Compares one returned word, field by field, with the oldest prediction.
    task check_word(out_word_t got);
      out_word_t want;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("word %h arrived with nothing pending", got));
        return;
      end
      want = pending_bytes.pop_front();
      n_words++;
      if (got.data_byte !== want.data_byte)
        report_mismatch($sformatf("data_byte %h, wanted %h", got.data_byte, want.data_byte));
      if (got.last_byte !== want.last_byte)
        report_mismatch($sformatf("last_byte %b, wanted %b", got.last_byte, want.last_byte));
      if (got.error_code !== want.error_code)
        report_mismatch($sformatf("error_code %0d, wanted %0d",
                                  got.error_code, want.error_code));
    endtask
  endclass

  // Every input of the block starts at a known value.
  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  in_word_t  in_word    = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  out_word_t out_word;

  // Idle mix of the current phase, in percent of cycles. They are changed
  // with nonblocking writes so both driving processes see them at the same
  // falling edge.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // The long receiver hold-off is requested here and counted down by the
  // receiver process itself.
  logic hold_armed = 1'b0;
  int   hold_left  = 0;

  lzw_string_tracker sb;

  lzw_code_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // Both channels are sampled at the rising edge. Inputs only move on the
  // falling edge, so what is seen here is what the block saw.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.expand_code(in_word);
      if (out_valid && out_ready) sb.check_word(out_word);
    end
  end

  // Receiver: random stalls at the phase's rate, or a long hold-off when one
  // has been requested, so the block backs up and drops in_ready.
  always @(negedge clk) begin
    if (hold_armed) begin
      hold_left = HOLD_CYCLES;
      hold_armed <= 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one code word, holds it until it is taken, then maybe idles.
  // Called at a falling edge and returns at a falling edge.
  task automatic send_word(in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_code(int unsigned code, bit restart);
    in_word_t w;
    w.code_word  = code[CODE_W-1:0];
    w.new_stream = restart;
    send_word(w);
  endtask

  // Sender pause: nothing is offered until every predicted word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_bytes.size() != 0);
  endtask

  // Mostly well-formed codes with random content: plain bytes, existing
  // entries (recent ones often, so strings grow), and the next free entry.
  // About one code in twelve is noise or just past the next free entry.
  function automatic in_word_t pick_code();
    in_word_t    w;
    int unsigned nf;
    int unsigned lo;
    int unsigned hi;
    int          r;
    nf = sb.next_entry;
    r  = $urandom_range(99);
    w.new_stream = 1'b0;
    w.code_word  = CODE_W'($urandom_range(255));
    if (r < 4) begin
      w.new_stream = 1'b1;
    end else if (!sb.have_string) begin
      // Keep the byte so the stream gets going.
    end else if (r < 8 && nf < DICT_ENTRIES - 1) begin
      hi = (nf + 8 < DICT_ENTRIES) ? nf + 8 : DICT_ENTRIES - 1;
      w.code_word = CODE_W'($urandom_range(hi, nf + 1));
    end else if (r < 12) begin
      w.code_word  = CODE_W'($urandom);
      w.new_stream = ($urandom_range(9) == 0);
    end else if (r < 35 || nf == FIRST_ENTRY) begin
      // Plain byte already chosen.
    end else if (r < 55) begin
      w.code_word = CODE_W'($urandom_range(nf - 1, FIRST_ENTRY));
    end else if (r < 78) begin
      lo = (nf > FIRST_ENTRY + 8) ? nf - 8 : FIRST_ENTRY;
      w.code_word = CODE_W'($urandom_range(nf - 1, lo));
    end else if (nf < DICT_ENTRIES) begin
      w.code_word = CODE_W'(nf);
    end
    return w;
  endfunction

  initial begin
    #RUN_LIMIT;
    $display("Timed out with %0d words still pending.", sb.pending_bytes.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int i;
    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed codes, no idling. The stream is fresh after reset.
    send_code(300, 1'b0);     // no previous string yet, so an entry is rejected
    send_code(16'hFFFF, 1'b0);
    send_code(65, 1'b0);      // first byte of the stream
    send_code(66, 1'b0);
    send_code(256, 1'b0);     // first dictionary entry
    send_code(258, 1'b0);     // next free entry: previous string plus its head
    send_code(300, 1'b0);     // past the next free entry
    send_code(260, 1'b0);     // one past the next free entry
    send_code(259, 1'b0);
    send_code(0, 1'b0);
    send_code(255, 1'b0);
    send_code(16'hFFFF, 1'b1); // restart still happens although the code fails
    send_code(256, 1'b0);      // so this one has no previous string
    send_code(8'h80, 1'b1);
    send_code(8'h80, 1'b0);
    send_code(256, 1'b0);
    send_code(257, 1'b0);
    send_code(8'h7F, 1'b1);    // restart in the middle of a stream
    send_code(257, 1'b0);
    wait_drained();

    // Phase without idling: a string grown one byte per code through the
    // next free entry until it overflows, then entries at and just past the
    // longest string that may be emitted, then random codes.
    send_code($urandom_range(255), 1'b1);
    for (i = 0; i < MAX_STRING + 2; i++) send_code(sb.next_entry, 1'b0);
    send_code(FIRST_ENTRY + MAX_STRING - 2, 1'b0);
    send_code(FIRST_ENTRY + MAX_STRING - 1, 1'b0);
    send_code(FIRST_ENTRY + 1, 1'b0);
    for (i = 0; i < 6; i++) send_word(pick_code());
    wait_drained();

    // Sender idles about half the cycles.
    send_idle_pct <= 50;
    for (i = 0; i < 10; i++) send_word(pick_code());
    wait_drained();

    // Receiver stalls about half the cycles, with one long hold-off while
    // the sender keeps offering codes.
    send_idle_pct <= 0;
    stall_pct     <= 50;
    for (i = 0; i < 10; i++) begin
      if (i == 4) hold_armed <= 1'b1;
      send_word(pick_code());
    end
    wait_drained();

    // Both sides idle about a fifth of the cycles.
    send_idle_pct <= 21;
    stall_pct     <= 21;
    for (i = 0; i < 10; i++) send_word(pick_code());
    wait_drained();

    // Anything arriving now is a word nobody asked for.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_bytes.size() != 0)
      sb.report_mismatch($sformatf("%0d words never arrived", sb.pending_bytes.size()));

    $display("Decoded %0d codes into %0d words: %0d rejected codes, %0d over-long strings.",
             sb.n_codes, sb.n_words, sb.n_bad_code, sb.n_too_long);
    $display("Longest string %0d bytes, dictionary filled %0d time(s), %0d mismatches.",
             sb.longest, sb.n_full, sb.fails);
    if (sb.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
